FILE: rtl/core/iffdf_pkg.sv
package iffdf_pkg;

  // register indexes on the configuration port
  localparam logic REG_SHORT_SIZES    = 1'b0;
  localparam logic REG_WITH_FORM_TYPE = 1'b1;

  localparam int unsigned PADDR_W = 3;

  // header byte positions (last index of each header field)
  localparam logic [1:0] HDR_LAST       = 2'd3;
  localparam logic [1:0] LEN_LAST_SHORT = 2'd1;
  localparam logic [1:0] LEN_LAST_LONG  = 2'd3;

  typedef enum logic [3:0] {
    PH_FORM    = 4'b0001,
    PH_ID      = 4'b0010,
    PH_LEN     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic short_sizes;
    logic with_form_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic [31:0] byte_offset;
    logic        chunk_end;
    logic        empty_chunk;
    logic        truncated;
    logic [31:0] form_kind;
  } result_item_t;

endpackage

FILE: rtl/core/iff_chunk_deframer.sv
// IFF chunk deframer: parses an IFF container body one byte per transfer.
// Input channel byte_valid/byte_ready/byte_item carries a data byte and an
// end_of_data flag marking the last byte of a buffer. Output channel
// result_valid/result_ready/result_item carries payload bytes tagged with
// chunk id, declared length, offset and end mark, plus empty-chunk and
// truncation markers; header bytes produce no transfer unless the buffer
// ends inside a header or a zero length completes. Registers on the APB
// port: short_sizes at 0x0 and with_form_type at 0x4; write them only while
// the block is idle.
// A result is valid in the cycle after its byte transfer.
// Throughput: one byte per cycle while byte_ready is high, set by the
// combinational parse step between the parser state and the two-entry
// result buffer. When the receiver stalls, the buffer absorbs up to two
// results and then byte_ready drops until a result transfer frees a slot.
// Reset (synchronous, active high) empties the buffer, sets short_sizes to 0
// and with_form_type to 1 and returns the parser to the form type phase.
module iff_chunk_deframer
  import iffdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  byte_item_t         byte_item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_item_t       result_item
);

  cfg_t         cfg;
  logic         step;
  logic         res_valid;
  result_item_t res;
  logic         space;

  assign byte_ready = space;
  assign step       = byte_valid && byte_ready;

  iffdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iffdf_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .item      (byte_item),
    .res_valid (res_valid),
    .res       (res)
  );

  iffdf_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_data    (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

FILE: rtl/core/iffdf_regs.sv
module iffdf_regs
  import iffdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_sizes    <= 1'b0;
      cfg.with_form_type <= 1'b1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SHORT_SIZES:    cfg.short_sizes    <= pwdata[0];
        REG_WITH_FORM_TYPE: cfg.with_form_type <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_SHORT_SIZES:    prdata = {31'd0, cfg.short_sizes};
      REG_WITH_FORM_TYPE: prdata = {31'd0, cfg.with_form_type};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/core/iffdf_parse.sv
module iffdf_parse
  import iffdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         step,
  input  byte_item_t   item,
  output logic         res_valid,
  output result_item_t res
);

  phase_t      phase, phase_next;
  logic [1:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [31:0] left, left_next;
  logic [31:0] offset, offset_next;
  logic [31:0] form_word, form_word_next;

  // one byte of parsing
  always_comb begin
    phase_t      ph;
    logic [1:0]  hc;
    logic [1:0]  len_last;
    logic [31:0] left_dec;
    logic        last_byte;
    logic        eod;
    logic [7:0]  b;

    b        = item.data_byte;
    eod      = item.end_of_data;
    ph       = phase;
    hc       = hdr_cnt;
    len_last = cfg.short_sizes ? LEN_LAST_SHORT : LEN_LAST_LONG;
    left_dec = left - 32'd1;
    last_byte = (left_dec == 32'd0);

    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    tag_next       = tag;
    len_next       = len;
    left_next      = left;
    offset_next    = offset;
    form_word_next = form_word;

    res_valid        = 1'b0;
    res.payload_byte = 8'd0;
    res.byte_offset  = 32'd0;
    res.chunk_end    = 1'b0;
    res.empty_chunk  = 1'b0;
    res.truncated    = 1'b0;

    // form type skipped: byte is the first id byte
    if (phase == PH_FORM && !cfg.with_form_type) begin
      ph = PH_ID;
      hc = 2'd0;
    end

    case (ph)
      PH_FORM: begin
        form_word_next = (hc == 2'd0) ? {24'd0, b} : {form_word[23:0], b};
        if (hc == HDR_LAST) begin
          phase_next   = PH_ID;
          hdr_cnt_next = 2'd0;
        end else begin
          hdr_cnt_next = hc + 2'd1;
          res_valid     = eod;
          res.truncated = 1'b1;
        end
      end
      PH_ID: begin
        tag_next = (hc == 2'd0) ? {24'd0, b} : {tag[23:0], b};
        if (hc == HDR_LAST) begin
          phase_next   = PH_LEN;
          hdr_cnt_next = 2'd0;
        end else begin
          phase_next   = PH_ID;
          hdr_cnt_next = hc + 2'd1;
        end
        res_valid     = eod;
        res.truncated = 1'b1;
      end
      PH_LEN: begin
        len_next = (hc == 2'd0) ? {24'd0, b} : {len[23:0], b};
        if (hc >= len_last) begin
          hdr_cnt_next = 2'd0;
          if (len_next == 32'd0) begin
            // zero-length chunk marker
            phase_next      = PH_ID;
            res_valid       = 1'b1;
            res.chunk_end   = 1'b1;
            res.empty_chunk = 1'b1;
          end else begin
            phase_next    = PH_PAYLOAD;
            left_next     = len_next;
            offset_next   = 32'd0;
            res_valid     = eod;
            res.truncated = 1'b1;
          end
        end else begin
          hdr_cnt_next  = hc + 2'd1;
          res_valid     = eod;
          res.truncated = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        left_next        = left_dec;
        offset_next      = offset + 32'd1;
        res_valid        = 1'b1;
        res.payload_byte = b;
        res.byte_offset  = offset;
        res.chunk_end    = last_byte;
        res.truncated    = eod && !last_byte;
        if (last_byte) begin
          phase_next   = PH_ID;
          hdr_cnt_next = 2'd0;
        end
      end
      default: begin
        phase_next = PH_FORM;
      end
    endcase

    // result carries tag and length as updated by this byte
    res.chunk_tag    = tag_next;
    res.chunk_length = len_next;
    res.form_kind    = form_word_next;
    res_valid        = res_valid && step;

    // end of buffer restarts the parse
    if (eod) begin
      phase_next   = PH_FORM;
      hdr_cnt_next = 2'd0;
      tag_next     = 32'd0;
      len_next     = 32'd0;
      left_next    = 32'd0;
      offset_next  = 32'd0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FORM;
      hdr_cnt   <= 2'd0;
      tag       <= 32'd0;
      len       <= 32'd0;
      left      <= 32'd0;
      offset    <= 32'd0;
      form_word <= 32'd0;
    end else if (step) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      tag       <= tag_next;
      len       <= len_next;
      left      <= left_next;
      offset    <= offset_next;
      form_word <= form_word_next;
    end
  end

  // checks
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.end_of_data |=> phase == PH_FORM && hdr_cnt == 2'd0)
    else $error("parser did not restart after end of buffer");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> left != 32'd0)
    else $error("payload phase with no bytes left");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.empty_chunk |-> res.chunk_end && !res.truncated
      && res.chunk_length == 32'd0)
    else $error("malformed empty chunk marker");

endmodule

FILE: rtl/core/iffdf_obuf.sv
module iffdf_obuf
  import iffdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_item_t push_data,
  output logic         space,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  result_item_t slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != 2'd0);
  assign space        = (count != 2'd2);
  assign result_item  = slot[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import iffdf_pkg::*;

  // one directed stimulus row: a register write or a byte transfer
  typedef struct {
    bit           is_cfg;
    logic         reg_idx;
    logic [7:0]   data;
    logic         eod;
    bit           pinned;
    bit           has_res;
    result_item_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               byte_valid = 1'b0;
  logic               byte_ready;
  byte_item_t         byte_item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_item_t       result_item;

  // deframer prediction state
  logic         cfg_short;
  logic         cfg_form;
  phase_t       prs_phase;
  logic [1:0]   hdr_cnt;
  logic [31:0]  cur_tag;
  logic [31:0]  cur_len;
  logic [31:0]  left_cnt;
  logic [31:0]  off_cnt;
  logic [31:0]  form_reg;

  result_item_t want_q[$];
  byte_item_t   stim_q[$];
  dir_row_t     dir_q[$];
  int           bad_n = 0;
  int           rx_got = 0;
  int           rx_hold = 0;
  bit           calm = 1'b0;

  iff_chunk_deframer DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .byte_valid, .byte_ready, .byte_item, .result_valid, .result_ready, .result_item
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic byte_item_t mk_item(logic [7:0] d, logic e);
    byte_item_t it;
    it.data_byte = d;
    it.end_of_data = e;
    return it;
  endfunction

  // result fields from the current chunk state
  function automatic result_item_t tag_result(logic [7:0] b, logic [31:0] off, logic last,
                                              logic empty, logic trunc);
    result_item_t r;
    r.payload_byte = b;
    r.chunk_tag    = cur_tag;
    r.chunk_length = cur_len;
    r.byte_offset  = off;
    r.chunk_end    = last;
    r.empty_chunk  = empty;
    r.truncated    = trunc;
    r.form_kind    = form_reg;
    return r;
  endfunction

  // advance the deframer by one byte, return 1 when it yields a result
  function automatic bit deframe_step(input byte_item_t it, output result_item_t r);
    logic [7:0] b;
    logic       eod;
    logic       done;
    logic       last;
    logic [1:0] need;
    bit         hit;
    b = it.data_byte;
    eod = it.end_of_data;
    hit = 1'b0;
    r = '0;
    if (prs_phase == PH_FORM && !cfg_form) begin
      prs_phase = PH_ID;
      hdr_cnt = '0;
    end
    case (prs_phase)
      PH_FORM: begin
        done = (hdr_cnt == HDR_LAST);
        form_reg = (hdr_cnt == 2'd0) ? {24'h0, b} : {form_reg[23:0], b};
        if (done) begin
          prs_phase = PH_ID;
          hdr_cnt = '0;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
        if (eod && !done) begin
          r = tag_result(8'h00, 32'h0, 1'b0, 1'b0, 1'b1);
          hit = 1'b1;
        end
      end
      PH_ID: begin
        cur_tag = (hdr_cnt == 2'd0) ? {24'h0, b} : {cur_tag[23:0], b};
        if (hdr_cnt == HDR_LAST) begin
          prs_phase = PH_LEN;
          hdr_cnt = '0;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
        if (eod) begin
          r = tag_result(8'h00, 32'h0, 1'b0, 1'b0, 1'b1);
          hit = 1'b1;
        end
      end
      PH_LEN: begin
        need = cfg_short ? LEN_LAST_SHORT : LEN_LAST_LONG;
        cur_len = (hdr_cnt == 2'd0) ? {24'h0, b} : {cur_len[23:0], b};
        if (hdr_cnt >= need) begin
          hdr_cnt = '0;
          if (cur_len == 32'h0) begin
            prs_phase = PH_ID;
            r = tag_result(8'h00, 32'h0, 1'b1, 1'b1, 1'b0);
            hit = 1'b1;
          end else begin
            prs_phase = PH_PAYLOAD;
            left_cnt = cur_len;
            off_cnt = '0;
            if (eod) begin
              r = tag_result(8'h00, 32'h0, 1'b0, 1'b0, 1'b1);
              hit = 1'b1;
            end
          end
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
          if (eod) begin
            r = tag_result(8'h00, 32'h0, 1'b0, 1'b0, 1'b1);
            hit = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        left_cnt = left_cnt - 32'd1;
        last = (left_cnt == 32'h0);
        r = tag_result(b, off_cnt, last, 1'b0, eod && !last);
        hit = 1'b1;
        off_cnt = off_cnt + 32'd1;
        if (last) begin
          prs_phase = PH_ID;
          hdr_cnt = '0;
        end
      end
      default: ;
    endcase
    // end of buffer: back to the form type phase
    if (eod) begin
      prs_phase = PH_FORM;
      hdr_cnt = '0;
      cur_tag = '0;
      cur_len = '0;
      left_cnt = '0;
      off_cnt = '0;
    end
    return hit;
  endfunction

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 34);
  endfunction

  // offer one byte until its transfer, then predict its result
  task automatic push_byte(input byte_item_t it, output bit has, output result_item_t r);
    while (take_gap()) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (!byte_ready);
    has = deframe_step(it, r);
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic drain_results();
    byte_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= {31'($urandom()), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SHORT_SIZES) cfg_short = v;
    else cfg_form = v;
  endtask

  // one container buffer: optional form type, a few chunks, sometimes cut short
  task automatic build_buffer();
    byte_item_t  body[$];
    int          n_chunks;
    int          sel;
    int          pay;
    int          cut;
    bit          huge;
    logic [31:0] lv;
    huge = 1'b0;
    if (cfg_form) repeat (4) body.insert(body.size(), mk_item(8'($urandom_range(255)), 1'b0));
    n_chunks = $urandom_range(1, 4);
    for (int c = 0; c < n_chunks && !huge; c++) begin
      repeat (4) body.insert(body.size(), mk_item(8'($urandom_range(255)), 1'b0));
      sel = $urandom_range(99);
      if (sel < 15) lv = 32'd0;
      else if (sel < 90) lv = 32'($urandom_range(1, 10));
      else if (sel < 97) lv = 32'($urandom_range(11, 40));
      else begin
        // length far beyond the buffer, so the payload gets truncated
        lv = $urandom() | 32'h0000_0080;
        huge = 1'b1;
      end
      if (!cfg_short) begin
        body.insert(body.size(), mk_item(lv[31:24], 1'b0));
        body.insert(body.size(), mk_item(lv[23:16], 1'b0));
      end
      body.insert(body.size(), mk_item(lv[15:8], 1'b0));
      body.insert(body.size(), mk_item(lv[7:0], 1'b0));
      pay = huge ? $urandom_range(0, 6) : int'(lv);
      repeat (pay) body.insert(body.size(), mk_item(8'($urandom_range(255)), 1'b0));
    end
    if ($urandom_range(99) < 20) begin
      cut = $urandom_range(1, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    body[body.size()-1].end_of_data = 1'b1;
    foreach (body[i]) stim_q.insert(stim_q.size(), body[i]);
  endtask

  function automatic void add_byte(logic [7:0] d, logic e);
    dir_row_t row;
    row = '{default: '0};
    row.data = d;
    row.eod = e;
    dir_q.insert(dir_q.size(), row);
  endfunction

  function automatic void add_pin(logic [7:0] d, logic e, bit has, result_item_t res);
    dir_row_t row;
    row = '{default: '0};
    row.data = d;
    row.eod = e;
    row.pinned = 1'b1;
    row.has_res = has;
    row.res = res;
    dir_q.insert(dir_q.size(), row);
  endfunction

  function automatic void add_cfg(logic idx, logic v);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.data = {7'h0, v};
    dir_q.insert(dir_q.size(), row);
  endfunction

  // result side: compare each transfer with the oldest prediction
  task automatic check_result(input result_item_t got);
    result_item_t want;
    if (want_q.size() == 0) begin
      bad_n++;
      if (bad_n <= 10)
        $display("unexpected result: byte %h tag %h len %h off %h end %b empty %b trunc %b form %h",
                 got.payload_byte, got.chunk_tag, got.chunk_length, got.byte_offset,
                 got.chunk_end, got.empty_chunk, got.truncated, got.form_kind);
      return;
    end
    want = want_q.pop_front();
    if (got.payload_byte !== want.payload_byte || got.chunk_tag !== want.chunk_tag ||
        got.chunk_length !== want.chunk_length || got.byte_offset !== want.byte_offset ||
        got.chunk_end !== want.chunk_end || got.empty_chunk !== want.empty_chunk ||
        got.truncated !== want.truncated || got.form_kind !== want.form_kind) begin
      bad_n++;
      if (bad_n <= 10) begin
        $display("mismatch exp: byte %h tag %h len %h off %h end %b empty %b trunc %b form %h",
                 want.payload_byte, want.chunk_tag, want.chunk_length, want.byte_offset,
                 want.chunk_end, want.empty_chunk, want.truncated, want.form_kind);
        $display("         got: byte %h tag %h len %h off %h end %b empty %b trunc %b form %h",
                 got.payload_byte, got.chunk_tag, got.chunk_length, got.byte_offset,
                 got.chunk_end, got.empty_chunk, got.truncated, got.form_kind);
      end
    end
  endtask

  // receiver: random stalls, plus two long hold-offs while the sender keeps going
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        check_result(result_item);
        rx_got++;
        if (rx_got == 200 || rx_got == 600) rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]   cfg_plan [6];
    bit           has;
    result_item_t r;
    int           sent;

    cfg_plan = '{2'b01, 2'b10, 2'b00, 2'b11, 2'b01, 2'b10};
    cfg_short = 1'b0;
    cfg_form = 1'b1;
    prs_phase = PH_FORM;
    hdr_cnt = '0;
    cur_tag = '0;
    cur_len = '0;
    left_cnt = '0;
    off_cnt = '0;
    form_reg = '0;

    // reset settings: form type, id, maximum length, payload cut by end of buffer
    add_byte(8'h41, 1'b0); add_byte(8'h49, 1'b0); add_byte(8'h46, 1'b0); add_byte(8'h46, 1'b0);
    add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_pin(8'h00, 1'b0, 1'b1, '{8'h00, 32'hFF00FF00, 32'hFFFFFFFF, 32'h0,
                                  1'b0, 1'b0, 1'b0, 32'h41494646});
    add_pin(8'h80, 1'b1, 1'b1, '{8'h80, 32'hFF00FF00, 32'hFFFFFFFF, 32'h1,
                                  1'b0, 1'b0, 1'b1, 32'h41494646});
    // buffer ends inside the form type
    add_byte(8'h12, 1'b0);
    add_pin(8'h34, 1'b1, 1'b1, '{8'h00, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, 32'h00001234});
    // buffer ends right after a complete form type: nothing comes out
    add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_pin(8'hFF, 1'b1, 1'b0, '0);
    // no form type, short lengths; the old form type stays on every result
    add_cfg(REG_WITH_FORM_TYPE, 1'b0);
    add_cfg(REG_SHORT_SIZES, 1'b1);
    add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_pin(8'h00, 1'b1, 1'b1, '{8'h00, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF});
    // buffer ends on the byte that completes a nonzero length
    add_byte(8'h78, 1'b0); add_byte(8'h79, 1'b0); add_byte(8'h7A, 1'b0); add_byte(8'h77, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_pin(8'hFF, 1'b1, 1'b1, '{8'h00, 32'h78797A77, 32'h0000FFFF, 32'h0,
                                  1'b0, 1'b0, 1'b1, 32'hFFFFFFFF});
    // buffer ends inside the chunk id
    add_pin(8'hAA, 1'b1, 1'b1, '{8'h00, 32'h000000AA, 32'h0, 32'h0,
                                  1'b0, 1'b0, 1'b1, 32'hFFFFFFFF});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        drain_results();
        reg_write(dir_q[i].reg_idx, dir_q[i].data[0]);
      end else begin
        push_byte(mk_item(dir_q[i].data, dir_q[i].eod), has, r);
        if (dir_q[i].pinned) begin
          if (dir_q[i].has_res) want_q.insert(want_q.size(), dir_q[i].res);
        end else if (has) begin
          want_q.insert(want_q.size(), r);
        end
      end
    end

    // random phases; each one stops mid-stream, so settings change anywhere in a buffer
    for (int p = 0; p < 6; p++) begin
      drain_results();
      reg_write(REG_SHORT_SIZES, cfg_plan[p][1]);
      reg_write(REG_WITH_FORM_TYPE, cfg_plan[p][0]);
      calm = (p == 2);
      stim_q = {};
      sent = 0;
      while (sent < 235) begin
        if (stim_q.size() == 0) begin
          if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6))
              stim_q.insert(stim_q.size(),
                            mk_item(8'($urandom_range(255)), $urandom_range(3) == 0));
          end else begin
            build_buffer();
          end
        end
        push_byte(stim_q.pop_front(), has, r);
        if (has) want_q.insert(want_q.size(), r);
        sent++;
        if (p == 4 && sent == 120) drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (bad_n == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
